@@ sv/timed_release_packet_fifo_unit_defines.svh @@
// Assertion macros shared by the timed release packet FIFO.
// No dependencies; include by bare file name where assertions are written.
`ifndef TIMED_RELEASE_PACKET_FIFO_UNIT_DEFINES_SVH
`define TIMED_RELEASE_PACKET_FIFO_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define TRPF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define TRPF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/trpf_pkg.sv @@
// Types and constants of the timed release packet FIFO.
// No dependencies; imported by the slot store, the top level and the testbench.
`timescale 1ns / 1ps

package trpf_pkg;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_ARG   = 2'd1;
    localparam logic [1:0] ST_BAD_STATE = 2'd2;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    localparam logic [31:0] SEQ_LIMIT = 32'hFFFF_FFFF;

    // Per-slot bookkeeping stored beside the payload.
    typedef struct packed {
        logic [15:0] block;
        logic [31:0] tick;
        logic [31:0] seq;
    } t_meta;

    // Controls from the queue logic to the slot store.
    typedef struct packed {
        logic wr;     // store one beat at the tail
        logic pop;    // advance the head
        logic empty;  // queue empty before this update
    } t_store_ctl;

endpackage

@@ sv/timed_release_packet_fifo_unit.sv @@
// Top level of the timed release packet FIFO: input register, queue logic, result register.
// Depends on trpf_pkg, trpf_slot_store and timed_release_packet_fifo_unit_defines.svh.
//
// Each beat on the input channel is an enqueue or a dequeue-if-due and yields exactly one
// result beat. The block sustains one beat per cycle while the consumer keeps up: a beat is
// held in the input register, the queue update and status are decided from it there, and
// the result is registered in the output register. Ready drops only while the result
// register is held by a stalled consumer. The head entry is kept in registers and its
// successor is prefetched from the slot memory's single registered read port every cycle,
// so back-to-back pops do not wait on a memory read. Slot contents are not cleared at
// reset; only data from written slots ever reaches the outputs, and no clearing pass is run.
`timescale 1ns / 1ps

`include "timed_release_packet_fifo_unit_defines.svh"

module timed_release_packet_fifo_unit import trpf_pkg::*; #(
    parameter int QUEUE_DEPTH   = 16,
    parameter int PAYLOAD_BYTES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_operation,
    input  logic [15:0] i_block_id,
    input  logic [63:0] i_payload,
    input  logic [7:0]  i_length,
    input  logic [31:0] i_tick,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [15:0] o_out_block_id,
    output logic [31:0] o_out_tick,
    output logic [31:0] o_out_sequence,
    output logic [63:0] o_out_payload,
    output logic [4:0]  o_occupancy
);

    localparam int PW = 8 * PAYLOAD_BYTES;
    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = CW + 1;

    function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] idx);
        logic [IW-1:0] res;
        if (idx == IW'(QUEUE_DEPTH - 1)) begin
            res = '0;
        end else begin
            res = idx + 1'b1;
        end
        return res;
    endfunction

    // Input register
    logic          r_in_vld;
    logic          r_op;
    logic [15:0]   r_blk;
    logic [PW-1:0] r_pay;
    logic [7:0]    r_len;
    logic [31:0]   r_tick;

    // Queue state
    logic [IW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic [31:0]   r_prev_tick, n_prev_tick;
    logic [31:0]   r_seq, n_seq;
    logic          r_tick_flag, n_tick_flag;

    // Result register
    logic          r_out_vld;
    logic [1:0]    r_status;
    logic [15:0]   r_o_blk;
    logic [31:0]   r_o_tick;
    logic [31:0]   r_o_seq;
    logic [63:0]   r_o_pay;
    logic [4:0]    r_occ;

    logic          adv, fire, in_take;
    logic          is_enq, len_ok, full, empty, seq_done, due;
    logic          enq_ok, deq_ok;
    logic [1:0]    status;
    logic [31:0]   wr_tick;
    logic [SW-1:0] tail_sum;
    logic [IW-1:0] wr_idx, rd_idx;
    t_store_ctl    store_ctl;
    t_meta         wr_meta, head_meta;
    logic [PW-1:0] head_pay;

    assign adv     = !r_out_vld || i_ready;
    assign fire    = r_in_vld && adv;
    assign o_ready = !r_in_vld || adv;
    assign in_take = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (fire) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_op   <= i_operation;
            r_blk  <= i_block_id;
            r_pay  <= i_payload[PW-1:0];
            r_len  <= i_length;
            r_tick <= i_tick;
        end
    end

    assign is_enq   = (r_op == OP_ENQ);
    assign len_ok   = (r_len == 8'(PAYLOAD_BYTES));
    assign full     = (r_count == CW'(QUEUE_DEPTH));
    assign empty    = (r_count == '0);
    assign seq_done = (r_seq == SEQ_LIMIT);
    assign due      = !(head_meta.tick > r_tick);

    assign enq_ok = fire && is_enq && len_ok && !full && !seq_done;
    assign deq_ok = fire && !is_enq && !empty && due;

    always_comb begin
        if (is_enq) begin
            if (!len_ok) begin
                status = ST_BAD_ARG;
            end else if (full || seq_done) begin
                status = ST_BAD_STATE;
            end else begin
                status = ST_OK;
            end
        end else begin
            status = (empty || !due) ? ST_BAD_STATE : ST_OK;
        end
    end

    // Clamp the release tick so queue order never goes back in time.
    assign wr_tick = (r_tick_flag && (r_tick < r_prev_tick)) ? r_prev_tick : r_tick;

    assign tail_sum = SW'(r_head) + SW'(r_count);
    assign wr_idx   = (tail_sum >= SW'(QUEUE_DEPTH)) ? IW'(tail_sum - SW'(QUEUE_DEPTH))
                                                     : IW'(tail_sum);

    always_comb begin
        n_head      = r_head;
        n_count     = r_count;
        n_prev_tick = r_prev_tick;
        n_seq       = r_seq;
        n_tick_flag = r_tick_flag;
        if (enq_ok) begin
            n_count     = r_count + 1'b1;
            n_prev_tick = wr_tick;
            n_seq       = r_seq + 1'b1;
            n_tick_flag = 1'b1;
        end else if (deq_ok) begin
            n_head  = idx_inc(r_head);
            n_count = r_count - 1'b1;
        end
    end

    assign rd_idx = idx_inc(n_head);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_prev_tick <= '0;
            r_seq       <= '0;
            r_tick_flag <= 1'b0;
        end else begin
            r_head      <= n_head;
            r_count     <= n_count;
            r_prev_tick <= n_prev_tick;
            r_seq       <= n_seq;
            r_tick_flag <= n_tick_flag;
        end
    end

    assign store_ctl.wr    = enq_ok;
    assign store_ctl.pop   = deq_ok;
    assign store_ctl.empty = empty;

    assign wr_meta.block = r_blk;
    assign wr_meta.tick  = wr_tick;
    assign wr_meta.seq   = r_seq;

    trpf_slot_store #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .PW          (PW),
        .IW          (IW)
    ) u_store (
        .i_clk       (i_clk),
        .i_ctl       (store_ctl),
        .i_wr_idx    (wr_idx),
        .i_wr_meta   (wr_meta),
        .i_wr_pay    (r_pay),
        .i_rd_idx    (rd_idx),
        .o_head_meta (head_meta),
        .o_head_pay  (head_pay)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (fire) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    // Packet fields go out only on a successful pop; zero otherwise.
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_status <= status;
            r_occ    <= 5'(n_count);
            r_o_blk  <= deq_ok ? head_meta.block : 16'd0;
            r_o_tick <= deq_ok ? head_meta.tick  : 32'd0;
            r_o_seq  <= deq_ok ? head_meta.seq   : 32'd0;
            r_o_pay  <= deq_ok ? 64'(head_pay)   : 64'd0;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_status       = r_status;
    assign o_out_block_id = r_o_blk;
    assign o_out_tick     = r_o_tick;
    assign o_out_sequence = r_o_seq;
    assign o_out_payload  = r_o_pay;
    assign o_occupancy    = r_occ;

    `TRPF_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CW'(QUEUE_DEPTH), "fill count over depth")
    `TRPF_ASSERT_NEXT(a_seq_step, enq_ok, r_seq == $past(r_seq) + 32'd1, "sequence not stepped")
    `TRPF_ASSERT_NOW(a_fail_zero, o_valid && (o_status != ST_OK),
        (o_out_block_id == 16'd0) && (o_out_payload == 64'd0) && (o_out_sequence == 32'd0),
        "failed result carries packet data")
    `TRPF_ASSERT_NEXT(a_tick_mono, enq_ok, r_prev_tick >= $past(r_prev_tick) || !$past(r_tick_flag),
        "assigned tick went backwards")

endmodule

@@ sv/trpf_slot_store.sv @@
// Slot memory with a cached head entry and a prefetched successor.
// Depends on trpf_pkg.
`timescale 1ns / 1ps

module trpf_slot_store import trpf_pkg::*; #(
    parameter int QUEUE_DEPTH = 16,
    parameter int PW          = 64,
    parameter int IW          = 4
) (
    input  logic          i_clk,
    input  t_store_ctl    i_ctl,
    input  logic [IW-1:0] i_wr_idx,
    input  t_meta         i_wr_meta,
    input  logic [PW-1:0] i_wr_pay,
    input  logic [IW-1:0] i_rd_idx,
    output t_meta         o_head_meta,
    output logic [PW-1:0] o_head_pay
);

    t_meta         r_mem_meta [QUEUE_DEPTH];
    logic [PW-1:0] r_mem_pay  [QUEUE_DEPTH];

    t_meta         r_rd_meta;
    logic [PW-1:0] r_rd_pay;
    t_meta         r_head_meta;
    logic [PW-1:0] r_head_pay;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_mem_meta[i_wr_idx] <= i_wr_meta;
            r_mem_pay[i_wr_idx]  <= i_wr_pay;
        end
    end

    // Prefetch the entry after the next head; bypass a write to that slot.
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr && (i_wr_idx == i_rd_idx)) begin
            r_rd_meta <= i_wr_meta;
            r_rd_pay  <= i_wr_pay;
        end else begin
            r_rd_meta <= r_mem_meta[i_rd_idx];
            r_rd_pay  <= r_mem_pay[i_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr && i_ctl.empty) begin
            r_head_meta <= i_wr_meta;
            r_head_pay  <= i_wr_pay;
        end else if (i_ctl.pop) begin
            r_head_meta <= r_rd_meta;
            r_head_pay  <= r_rd_pay;
        end
    end

    assign o_head_meta = r_head_meta;
    assign o_head_pay  = r_head_pay;

endmodule

@@ test/timed_release_packet_fifo_unit_tb.sv @@
// Self-checking testbench for timed_release_packet_fifo_unit: enqueue and dequeue-if-due beats
// are predicted by a scoreboard class and compared field by field with every result beat.
// Depends on trpf_pkg and the RTL of the unit; needs no files or arguments.
`timescale 1ns / 1ps

module timed_release_packet_fifo_unit_tb;
    import trpf_pkg::*;

    localparam int QUEUE_DEPTH   = 16;
    localparam int PAYLOAD_BYTES = 8;
    localparam logic [63:0] PAYLOAD_MASK = {64{1'b1}} >> (64 - 8 * PAYLOAD_BYTES);
    localparam int STALL_LIMIT   = 4000;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] block;
        logic [31:0] tick;
        logic [31:0] seq;
        logic [63:0] payload;
        logic [4:0]  occupancy;
    } t_fifo_result;

    class release_fifo_scoreboard;
        logic [63:0] slot_payload [QUEUE_DEPTH];
        logic [31:0] slot_tick [QUEUE_DEPTH];
        logic [31:0] slot_seq [QUEUE_DEPTH];
        logic [15:0] slot_block [QUEUE_DEPTH];
        int head = 0;
        int fill = 0;
        logic [31:0] prev_tick = '0;
        logic [31:0] seq_count = '0;
        bit tick_set = 0;
        t_fifo_result awaited_results[$];
        int mismatches = 0;
        int checked = 0;
        int n_pushed = 0, n_popped = 0, n_bad_len = 0;
        int n_full = 0, n_empty = 0, n_not_due = 0, n_clamped = 0;

        // Update the queue state for one accepted beat and queue its result.
        function void note_beat(logic op, logic [15:0] block, logic [63:0] payload,
                                logic [7:0] length, logic [31:0] tick);
            t_fifo_result r;
            int slot;
            logic [31:0] release_tick;
            r = '0;
            if (op == OP_ENQ) begin
                if (length != PAYLOAD_BYTES) begin
                    r.status = ST_BAD_ARG;
                    n_bad_len++;
                end else if (fill >= QUEUE_DEPTH || seq_count == SEQ_LIMIT) begin
                    r.status = ST_BAD_STATE;
                    n_full++;
                end else begin
                    slot = (head + fill) % QUEUE_DEPTH;
                    release_tick = tick;
                    // never let release ticks run backwards in queue order
                    if (tick_set && tick < prev_tick) begin
                        release_tick = prev_tick;
                        n_clamped++;
                    end
                    slot_block[slot]   = block;
                    slot_tick[slot]    = release_tick;
                    slot_seq[slot]     = seq_count;
                    slot_payload[slot] = payload & PAYLOAD_MASK;
                    prev_tick = release_tick;
                    seq_count = seq_count + 1;
                    tick_set = 1;
                    fill++;
                    r.status = ST_OK;
                    n_pushed++;
                end
            end else begin
                if (fill == 0) begin
                    r.status = ST_BAD_STATE;
                    n_empty++;
                end else if (slot_tick[head] > tick) begin
                    r.status = ST_BAD_STATE;
                    n_not_due++;
                end else begin
                    r.status  = ST_OK;
                    r.block   = slot_block[head];
                    r.tick    = slot_tick[head];
                    r.seq     = slot_seq[head];
                    r.payload = slot_payload[head];
                    head = (head + 1) % QUEUE_DEPTH;
                    fill--;
                    n_popped++;
                end
            end
            r.occupancy = 5'(fill);
            awaited_results.push_back(r);
        endfunction

        task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            $display("%0t ns  beat %0d  %s: got %0h, want %0h", $time, checked, what, got, want);
            mismatches++;
        endtask

        task check_result(t_fifo_result got);
            t_fifo_result want;
            if (awaited_results.size() == 0) begin
                report_mismatch("result beat with none awaited, status", got.status, '0);
                return;
            end
            want = awaited_results.pop_front();
            if (got.status !== want.status)
                report_mismatch("status", got.status, want.status);
            if (got.block !== want.block)
                report_mismatch("block id", got.block, want.block);
            if (got.tick !== want.tick)
                report_mismatch("release tick", got.tick, want.tick);
            if (got.seq !== want.seq)
                report_mismatch("sequence", got.seq, want.seq);
            if (got.payload !== want.payload)
                report_mismatch("payload", got.payload, want.payload);
            if (got.occupancy !== want.occupancy)
                report_mismatch("occupancy", got.occupancy, want.occupancy);
            checked++;
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic        i_operation;
    logic [15:0] i_block_id;
    logic [63:0] i_payload;
    logic [7:0]  i_length;
    logic [31:0] i_tick;
    logic        o_valid;
    logic        i_ready;
    logic [1:0]  o_status;
    logic [15:0] o_out_block_id;
    logic [31:0] o_out_tick;
    logic [31:0] o_out_sequence;
    logic [63:0] o_out_payload;
    logic [4:0]  o_occupancy;

    release_fifo_scoreboard sb;
    bit          idle_on;
    logic [31:0] cur_tick;
    int          enq_pct;
    int          stall_cycles;

    timed_release_packet_fifo_unit #(
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .PAYLOAD_BYTES(PAYLOAD_BYTES)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_operation   (i_operation),
        .i_block_id    (i_block_id),
        .i_payload     (i_payload),
        .i_length      (i_length),
        .i_tick        (i_tick),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_out_block_id(o_out_block_id),
        .o_out_tick    (o_out_tick),
        .o_out_sequence(o_out_sequence),
        .o_out_payload (o_out_payload),
        .o_occupancy   (o_occupancy)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Consumer side: stall at random while idling is on.
    always @(negedge i_clk) begin
        if (idle_on)
            i_ready <= ($urandom_range(99) >= 29);
        else
            i_ready <= 1'b1;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_result('{o_status, o_out_block_id, o_out_tick, o_out_sequence,
                              o_out_payload, o_occupancy});
    end

    // Drop the run when neither channel moves a beat for too long.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                     stall_cycles, sb.awaited_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Present one beat, hold it until accepted, then hand it to the scoreboard.
    task automatic send_beat(input logic op, input logic [15:0] block,
                             input logic [63:0] payload, input logic [7:0] length,
                             input logic [31:0] tick);
        @(negedge i_clk);
        while (idle_on && $urandom_range(99) < 29) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_operation <= op;
        i_block_id  <= block;
        i_payload   <= payload;
        i_length    <= length;
        i_tick      <= tick;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        sb.note_beat(op, block, payload, length, tick);
    endtask

    task automatic random_beat(input int enq_share);
        logic        op;
        logic [7:0]  length;
        logic [31:0] tick;
        int          pick;
        op = ($urandom_range(99) < enq_share) ? OP_ENQ : OP_DEQ;
        length = ($urandom_range(99) < 85) ? 8'(PAYLOAD_BYTES) : 8'($urandom_range(255));
        pick = $urandom_range(99);
        // keep requested ticks near a slowly advancing clock so clamping stays rare
        if (op == OP_ENQ)
            tick = (pick < 75) ? cur_tick + $urandom_range(40) : cur_tick - $urandom_range(60);
        else if (pick < 75)
            tick = cur_tick + $urandom_range(60);
        else if (pick < 90)
            tick = cur_tick - $urandom_range(100);
        else if (pick < 95)
            tick = '0;
        else
            tick = '1;
        cur_tick = cur_tick + $urandom_range(6);
        send_beat(op, 16'($urandom), {$urandom, $urandom}, length, tick);
    endtask

    initial begin
        sb           = new();
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_ready      = 1'b0;
        i_operation  = OP_ENQ;
        i_block_id   = '0;
        i_payload    = '0;
        i_length     = '0;
        i_tick       = '0;
        idle_on      = 1'b1;
        stall_cycles = 0;
        cur_tick     = 32'd1000;
        enq_pct      = 50;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_beat(OP_DEQ, '0, '0, 8'(PAYLOAD_BYTES), '0);
        send_beat(OP_ENQ, '0, '0, 8'd0, 32'd1000);
        send_beat(OP_ENQ, '1, '1, 8'd255, '1);
        send_beat(OP_ENQ, 16'h5a5a, 64'h0123_4567_89ab_cdef, 8'd9, 32'd1000);
        send_beat(OP_ENQ, '0, '0, 8'(PAYLOAD_BYTES), 32'd1000);
        send_beat(OP_ENQ, '1, '1, 8'(PAYLOAD_BYTES), 32'd500);
        send_beat(OP_DEQ, '0, '0, 8'(PAYLOAD_BYTES), 32'd999);
        send_beat(OP_DEQ, '0, '0, 8'(PAYLOAD_BYTES), 32'd1000);
        send_beat(OP_DEQ, '0, '0, 8'(PAYLOAD_BYTES), '1);
        send_beat(OP_DEQ, '0, '0, 8'(PAYLOAD_BYTES), '0);
        // fill to the brim, then one more
        for (int i = 0; i <= QUEUE_DEPTH; i++)
            send_beat(OP_ENQ, 16'($urandom), {$urandom, $urandom}, 8'(PAYLOAD_BYTES),
                      cur_tick + i);

        for (int ph = 0; ph < 15; ph++) begin
            idle_on = !(ph >= 4 && ph < 7);
            case (ph % 3)
                0: enq_pct = 25;
                1: enq_pct = 80;
                default: enq_pct = 50;
            endcase
            repeat (39) random_beat(enq_pct);
        end

        // top of the tick range: later requests clamp to it, and it is due only at the end
        idle_on = 1'b1;
        send_beat(OP_ENQ, 16'($urandom), {$urandom, $urandom}, 8'(PAYLOAD_BYTES), '1);
        send_beat(OP_ENQ, 16'($urandom), {$urandom, $urandom}, 8'(PAYLOAD_BYTES), 32'd7);
        for (int i = 0; i < 2 * QUEUE_DEPTH + 4; i++)
            send_beat(OP_DEQ, '0, '0, 8'(PAYLOAD_BYTES), i[0] ? 32'hFFFF_FFFF : 32'hFFFF_FFFE);
        @(negedge i_clk);
        i_valid <= 1'b0;

        while (sb.awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Checked %0d result beats: %0d pushes (%0d clamped), %0d pops.",
                 sb.checked, sb.n_pushed, sb.n_clamped, sb.n_popped);
        $display("Rejected: %0d bad length, %0d full, %0d empty, %0d not due.",
                 sb.n_bad_len, sb.n_full, sb.n_empty, sb.n_not_due);
        if (sb.mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
